// ----- sv/spg_pkg.sv -----
// Shared types, constants and helper functions of the swept pulse train generator.
package spg_pkg;

    // Tick rate of time_now and sweep switch
    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam bit          SWEEP_ENABLE     = 1'b1;

    // Widths
    localparam int TIME_W    = 34;
    localparam int SUM_W     = TIME_W + 1;
    localparam int FREQ_W    = 12;
    localparam int DIVISOR_W = FREQ_W - 1;
    localparam int PERIOD_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int DIV_CNT_W = $clog2(PERIOD_W + 1);

    // Register reset values
    localparam logic [31:0]        START_TIME_RST    = 32'd0;
    localparam logic [31:0]        WINDOW_LENGTH_RST = 32'd1000000;
    localparam logic signed [15:0] AMPLITUDE_RST     = 16'sd50;
    localparam logic [9:0]         BASE_FREQ_RST     = 10'd10;
    localparam logic [31:0]        PULSE_WIDTH_RST   = 32'd1000;
    localparam logic [31:0]        STEP_LENGTH_RST   = 32'd100000;
    localparam logic [9:0]         FREQ_STEP_RST     = 10'd1;
    localparam logic [9:0]         MAX_FREQ_RST      = 10'd100;

    // Command codes of an input beat
    localparam logic CMD_EVAL    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [2:0] {
        CFG_START_TIME,
        CFG_WINDOW_LENGTH,
        CFG_AMPLITUDE,
        CFG_BASE_FREQ,
        CFG_PULSE_WIDTH,
        CFG_STEP_LENGTH,
        CFG_FREQ_STEP,
        CFG_MAX_FREQ
    } spg_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_TURN,
        ST_DIV_GO,
        ST_DIVIDE,
        ST_PHASE_ON,
        ST_PHASE_OFF,
        ST_FINISH
    } spg_state_t;

    typedef struct packed {
        logic        command;
        logic [31:0] time_now;
    } spg_in_t;

    typedef struct packed {
        logic signed [15:0]       current_out;
        logic                     pulse_on;
        logic signed [FREQ_W-1:0] freq_now;
        logic                     in_window;
    } spg_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic check;
        logic step;
        logic turn;
        logic div_start;
        logic phase_on;
        logic phase_off;
        logic load_out;
    } spg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic restart;
        logic in_win;
        logic freq_pos;
        logic div_done;
        logic out_free;
    } spg_status_t;

    // Clamp an exact time sum to the largest stored time
    function automatic logic [TIME_W-1:0] sat_time(input logic [SUM_W-1:0] t);
        return t[SUM_W-1] ? {TIME_W{1'b1}} : t[TIME_W-1:0];
    endfunction

    // Clamp a one-bit-grown frequency back into its signed range
    function automatic logic signed [FREQ_W-1:0] sat_freq(input logic signed [FREQ_W:0] f);
        if (f[FREQ_W] != f[FREQ_W-1]) begin
            return {f[FREQ_W], {(FREQ_W-1){~f[FREQ_W]}}};
        end
        return f[FREQ_W-1:0];
    endfunction

endpackage

// ----- sv/swept_pulse_train_generator.sv -----
// Top level of the swept pulse train generator: controller plus datapath.
//
//   channel | signals                          | beat
//   --------+----------------------------------+------------------------------
//   in      | in_valid, in_ready, in_data      | command, time_now
//   out     | out_valid, out_ready, out_data   | current_out, pulse_on, freq_now, in_window
//   cfg     | cfg_we, cfg_index, cfg_data      | one register write per cycle
//
// Each beat runs to its result before the next is taken. Inside the window at a
// positive frequency it passes the bit-serial divider; at a non-positive one it
// skips the divider; a restart or a time outside the window skips to the result.
// Reset loads the register defaults and the start-of-sequence state; no clearing pass.
// The output register lets a new input beat enter while a result still waits;
// the next result waits in the controller until the output register frees.
module swept_pulse_train_generator
    import spg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  spg_in_t      in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output spg_out_t     out_data,
    input  logic         cfg_we,
    input  spg_cfg_idx_t cfg_index,
    input  logic [31:0]  cfg_data
);

    spg_cmd_t    cmd;
    spg_status_t status;

    spg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    spg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- sv/spg_div.sv -----
// Restoring divider: ticks per second over the frequency, one quotient bit per cycle.
module spg_div
    import spg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [PERIOD_W-1:0]  quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [PERIOD_W-1:0]  acc_reg, acc_next;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // Shift one dividend bit into the remainder and try a subtract
    assign trial = {rem_reg, acc_reg[PERIOD_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        acc_next     = acc_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = DIV_CNT_W'(PERIOD_W);
            rem_next     = '0;
            divisor_next = divisor;
            acc_next     = PERIOD_W'(TICKS_PER_SECOND);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor_reg}) : trial[DIVISOR_W-1:0];
            acc_next = {acc_reg[PERIOD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control flags under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        acc_reg     <= acc_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

// ----- sv/spg_datapath.sv -----
// Datapath: configuration registers, sweep and pulse state, period divider, result register.
module spg_datapath
    import spg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  spg_cfg_idx_t cfg_index,
    input  logic [31:0]  cfg_data,
    input  spg_in_t      in_data,
    input  logic         out_ready,
    output logic         out_valid,
    output spg_out_t     out_data,
    input  spg_cmd_t     cmd,
    output spg_status_t  status
);

    // Configuration
    logic [31:0]        start_time_reg;
    logic [31:0]        window_length_reg;
    logic signed [15:0] amplitude_reg;
    logic [9:0]         base_freq_reg;
    logic [31:0]        pulse_width_reg;
    logic [31:0]        step_length_reg;
    logic [9:0]         freq_step_reg;
    logic [9:0]         max_freq_reg;

    // Sequence state
    logic signed [FREQ_W-1:0] freq_reg;
    logic                     ascending_reg;
    logic [TIME_W-1:0]        step_start_reg;
    logic [TIME_W-1:0]        next_off_base_reg;
    logic [TIME_W-1:0]        next_on_base_reg;
    logic                     on_phase_reg;

    // Per-beat working registers
    logic        command_reg;
    logic [31:0] time_reg;
    logic        inside_reg;
    logic        step_hit_reg;
    logic        out_valid_reg;
    spg_out_t    out_data_reg;

    logic                     inside_c;
    logic [SUM_W-1:0]         step_end;
    logic                     step_due;
    logic signed [FREQ_W:0]   freq_ext;
    logic signed [FREQ_W:0]   step_ext;
    logic signed [FREQ_W:0]   freq_stepped;
    logic signed [FREQ_W:0]   freq_turned;
    logic                     above_max;
    logic                     freq_pos;
    logic [TIME_W-1:0]        time_ext;
    logic                     on_due;
    logic                     off_due;
    logic [SUM_W-1:0]         on_base_sum;
    logic [SUM_W-1:0]         off_base_sum;
    logic [SUM_W-1:0]         off_time;
    logic                     div_done;
    logic [PERIOD_W-1:0]      period;
    logic                     drive;

    assign time_ext = TIME_W'(time_reg);

    // Window test over the exact end time
    assign inside_c = (time_reg >= start_time_reg)
                   && ({1'b0, time_reg} <= ({1'b0, start_time_reg} + {1'b0, window_length_reg}));

    // Sweep step test and frequency arithmetic
    assign step_end     = {1'b0, step_start_reg} + SUM_W'(step_length_reg);
    assign step_due     = SWEEP_ENABLE && (SUM_W'(time_reg) >= step_end);
    assign freq_ext     = {freq_reg[FREQ_W-1], freq_reg};
    assign step_ext     = $signed({3'b000, freq_step_reg});
    assign freq_stepped = ascending_reg ? freq_ext + step_ext : freq_ext - step_ext;
    assign freq_turned  = freq_ext - $signed({2'b00, freq_step_reg, 1'b0});
    assign above_max    = freq_reg > $signed({2'b00, max_freq_reg});
    assign freq_pos     = !freq_reg[FREQ_W-1] && (|freq_reg);

    // Pulse edge tests
    assign on_due       = !on_phase_reg && (time_ext >= next_off_base_reg);
    assign off_time     = {1'b0, next_on_base_reg} + SUM_W'(pulse_width_reg);
    assign off_due      = on_phase_reg && (SUM_W'(time_reg) >= off_time);
    assign on_base_sum  = {1'b0, next_on_base_reg} + SUM_W'(period);
    assign off_base_sum = {1'b0, next_off_base_reg} + SUM_W'(period);

    spg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (freq_reg[DIVISOR_W-1:0]),
        .done     (div_done),
        .quotient (period)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg    <= START_TIME_RST;
            window_length_reg <= WINDOW_LENGTH_RST;
            amplitude_reg     <= AMPLITUDE_RST;
            base_freq_reg     <= BASE_FREQ_RST;
            pulse_width_reg   <= PULSE_WIDTH_RST;
            step_length_reg   <= STEP_LENGTH_RST;
            freq_step_reg     <= FREQ_STEP_RST;
            max_freq_reg      <= MAX_FREQ_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_TIME:    start_time_reg    <= cfg_data;
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                CFG_AMPLITUDE:     amplitude_reg     <= cfg_data[15:0];
                CFG_BASE_FREQ:     base_freq_reg     <= cfg_data[9:0];
                CFG_PULSE_WIDTH:   pulse_width_reg   <= cfg_data;
                CFG_STEP_LENGTH:   step_length_reg   <= cfg_data;
                CFG_FREQ_STEP:     freq_step_reg     <= cfg_data[9:0];
                CFG_MAX_FREQ:      max_freq_reg      <= cfg_data[9:0];
            endcase
        end
    end

    // Advance sweep and pulse state under controller commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg          <= $signed({2'b00, BASE_FREQ_RST});
            ascending_reg     <= 1'b1;
            step_start_reg    <= TIME_W'(START_TIME_RST);
            next_off_base_reg <= TIME_W'(START_TIME_RST);
            next_on_base_reg  <= TIME_W'(START_TIME_RST);
            on_phase_reg      <= 1'b1;
            inside_reg        <= 1'b0;
            step_hit_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.check)
            begin
                if (command_reg == CMD_RESTART)
                begin
                    freq_reg          <= $signed({2'b00, base_freq_reg});
                    step_start_reg    <= TIME_W'(start_time_reg);
                    next_off_base_reg <= TIME_W'(start_time_reg);
                    next_on_base_reg  <= TIME_W'(start_time_reg);
                    inside_reg        <= 1'b0;
                end
                else
                begin
                    inside_reg <= inside_c;
                end
            end
            if (cmd.step)
            begin
                step_hit_reg <= step_due;
                if (step_due)
                begin
                    step_start_reg    <= sat_time(step_end);
                    next_off_base_reg <= sat_time(step_end);
                    next_on_base_reg  <= sat_time(step_end);
                    on_phase_reg      <= 1'b1;
                    freq_reg          <= sat_freq(freq_stepped);
                end
            end
            if (cmd.turn && step_hit_reg && above_max)
            begin
                freq_reg      <= sat_freq(freq_turned);
                ascending_reg <= 1'b0;
            end
            if (cmd.phase_on && on_due)
            begin
                next_on_base_reg <= sat_time(on_base_sum);
                on_phase_reg     <= 1'b1;
            end
            if (cmd.phase_off && off_due)
            begin
                next_off_base_reg <= sat_time(off_base_sum);
                on_phase_reg      <= 1'b0;
            end
            // Drop the result once taken, raise it on a new load
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign drive = inside_reg && freq_pos && on_phase_reg;

    // Capture the input beat and build the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            command_reg <= in_data.command;
            time_reg    <= in_data.time_now;
        end
        if (cmd.load_out)
        begin
            out_data_reg.current_out <= drive ? amplitude_reg : 16'sd0;
            out_data_reg.pulse_on    <= drive;
            out_data_reg.freq_now    <= freq_reg;
            out_data_reg.in_window   <= inside_reg;
        end
    end

    assign status.restart  = (command_reg == CMD_RESTART);
    assign status.in_win   = inside_c;
    assign status.freq_pos = freq_pos;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending beat");

    // A loaded result is offered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not offered");

    // A driven pulse lies inside the window and carries the amplitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.pulse_on) |->
            (out_data_reg.in_window && out_data_reg.current_out == amplitude_reg))
        else $error("pulse driven outside window or with wrong value");

    // The divider only ever sees a positive frequency
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> freq_pos)
        else $error("divider started on a non-positive frequency");

endmodule

// ----- sv/spg_ctrl.sv -----
// Controller state machine: sequences one input beat through the datapath.
module spg_ctrl
    import spg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  spg_status_t status,
    output spg_cmd_t    cmd
);

    spg_state_t state_reg, state_next;

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.restart || !status.in_win)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_TURN;
            end
            ST_TURN:
            begin
                cmd.turn   = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                if (status.freq_pos)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_PHASE_ON;
                end
            end
            ST_PHASE_ON:
            begin
                cmd.phase_on = 1'b1;
                state_next   = ST_PHASE_OFF;
            end
            ST_PHASE_OFF:
            begin
                cmd.phase_off = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
